// ===== hdl/psrb_pkg.sv =====
// psrb_pkg: widths, register indexes, mode codes and divider constants of the blitter
// no dependencies; used by the interfaces, the top level and the checker
package psrb_pkg;

	localparam int X_W      = 10;   // source column and row
	localparam int DATA_W   = 32;   // pixel and framebuffer word
	localparam int ADDR_W   = 20;   // framebuffer word address
	localparam int COORD_W  = 12;   // screen position before the on-screen test
	localparam int OFS_W    = 9;    // vertical offset register
	localparam int MODE_W   = 2;
	localparam int IDX_W    = 2;    // configuration register index
	localparam int CFG_W    = 9;    // widest configuration register
	localparam int Q_W      = 9;    // quotient of a source coordinate by three or five
	localparam int NSLOT    = 4;    // most writes one source pixel can cause
	localparam int SLOT_W   = 2;

	// reciprocal multiply: floor(v * RECIP / 2**RECIP_SHIFT) == v / d for every 10-bit v
	localparam int RECIP_SHIFT = 12;
	localparam int PROD_W      = 21;
	localparam logic [PROD_W-1:0] RECIP3 = 21'd1366;
	localparam logic [PROD_W-1:0] RECIP5 = 21'd820;

	localparam logic [DATA_W-1:0] ALPHA_MASK = 32'hff00_0000;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_SCALE_MODE  = 2'd0;
	localparam logic [IDX_W-1:0] REG_SRC_FORMAT  = 2'd1;
	localparam logic [IDX_W-1:0] REG_VERT_OFFSET = 2'd2;
	localparam logic [IDX_W-1:0] REG_BACK_BUFFER = 2'd3;

	typedef enum logic [MODE_W-1:0] {
		MODE_ONE    = 2'd0,
		MODE_DOUBLE = 2'd1,
		MODE_UP34   = 2'd2,
		MODE_DOWN54 = 2'd3
	} scale_mode_t;

	typedef enum logic {
		FMT_RGB565 = 1'b0,
		FMT_ARGB   = 1'b1
	} src_format_t;

	typedef logic [COORD_W-1:0] coord_t;

endpackage

// ===== hdl/psrb_if.sv =====
// psrb_in_if and psrb_out_if: valid/ready channels for source pixels and framebuffer writes
// depends on psrb_pkg for the field widths
interface psrb_in_if;
	logic                          valid;
	logic                          ready;
	logic [psrb_pkg::X_W-1:0]      src_x;
	logic [psrb_pkg::X_W-1:0]      src_y;
	logic [psrb_pkg::DATA_W-1:0]   pixel;

	modport source (output valid, src_x, src_y, pixel, input ready);
	modport sink   (input valid, src_x, src_y, pixel, output ready);
endinterface

interface psrb_out_if;
	logic                          valid;
	logic                          ready;
	logic [psrb_pkg::ADDR_W-1:0]   word_address;
	logic [psrb_pkg::DATA_W-1:0]   word_data;
	logic                          last_write;

	modport source (output valid, word_address, word_data, last_write, input ready);
	modport sink   (input valid, word_address, word_data, last_write, output ready);
endinterface

// ===== hdl/pixel_scale_rotate_blitter.sv =====
// pixel_scale_rotate_blitter: scales one source pixel, rotates it by 180 degrees and
// issues framebuffer word writes; depends on psrb_pkg, psrb_in_if and psrb_out_if

// Each beat on in_ch carries one source pixel and its window coordinates. The pixel is
// converted to ARGB8888 with alpha forced to 0xff, mapped to up to four screen positions
// by the scale mode, rotated by 180 degrees and sent on out_ch as one framebuffer word
// write per position, into the back buffer selected by the back_buffer register.
// Positions off the screen are dropped; last_write marks the final write of a pixel, and
// a pixel whose positions are all off screen gives no write at all.
// Throughput: out_ch carries one write per cycle unless out_ch.ready stalls it, and a
// pixel stays in the candidate stage until its last write leaves; a pixel gives at most
// one write in one-to-one and five-to-four mode, up to four in double and three-to-four
// mode. The bound is the candidate stage, which hands one position a cycle, when the
// stages behind it do not stall, to rotation, row product and output; in_ch is taken
// while earlier pixels are in flight. Registers are written through cfg_we, cfg_index
// and cfg_data and must only change while nothing is in flight.
module pixel_scale_rotate_blitter #(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [psrb_pkg::IDX_W-1:0]    cfg_index,
	input  logic [psrb_pkg::CFG_W-1:0]    cfg_data,
	psrb_in_if.sink                       in_ch,
	psrb_out_if.source                    out_ch
);

	localparam int ROW_W = $clog2(SCREEN_HEIGHT);
	localparam int COL_W = $clog2(SCREEN_WIDTH);
	localparam int MUL_W = ROW_W + psrb_pkg::COORD_W;
	localparam psrb_pkg::coord_t            WIDTH_C  = psrb_pkg::COORD_W'(SCREEN_WIDTH);
	localparam psrb_pkg::coord_t            HEIGHT_C = psrb_pkg::COORD_W'(SCREEN_HEIGHT);
	localparam logic [ROW_W-1:0]            ROW_MAX  = ROW_W'(SCREEN_HEIGHT - 1);
	localparam logic [COL_W-1:0]            COL_MAX  = COL_W'(SCREEN_WIDTH - 1);
	localparam logic [psrb_pkg::ADDR_W-1:0] BUF_BASE =
		psrb_pkg::ADDR_W'(SCREEN_WIDTH * SCREEN_HEIGHT);

	// configuration registers
	psrb_pkg::scale_mode_t          scale_mode_q;
	psrb_pkg::src_format_t          src_format_q;
	logic [psrb_pkg::OFS_W-1:0]     vert_offset_q;
	logic                           back_buffer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_mode_q  <= psrb_pkg::MODE_ONE;
			src_format_q  <= psrb_pkg::FMT_RGB565;
			vert_offset_q <= '0;
			back_buffer_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				psrb_pkg::REG_SCALE_MODE: begin
					scale_mode_q <= psrb_pkg::scale_mode_t'(cfg_data[psrb_pkg::MODE_W-1:0]);
				end
				psrb_pkg::REG_SRC_FORMAT: begin
					src_format_q <= psrb_pkg::src_format_t'(cfg_data[0]);
				end
				psrb_pkg::REG_VERT_OFFSET: begin
					vert_offset_q <= cfg_data[psrb_pkg::OFS_W-1:0];
				end
				psrb_pkg::REG_BACK_BUFFER: begin
					back_buffer_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// handshake chain: a stage can load when it is empty or moves on in this cycle
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, free2, rdy3, rdy4, rdy5;
	logic take_in, ld2, send;

	assign rdy5 = !v_s5 || out_ch.ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy1 = !v_s1 || free2;
	assign take_in = in_ch.valid && rdy1;
	assign ld2     = v_s1 && free2;
	assign in_ch.ready = rdy1;

	// ---------------------------------------------------------------
	// stage 1: colour conversion and quotients by three and five
	// ---------------------------------------------------------------
	logic [psrb_pkg::PROD_W-1:0] px3, py3, px5, py5;
	logic [psrb_pkg::DATA_W-1:0] argb;

	always_comb begin
		px3 = psrb_pkg::PROD_W'(in_ch.src_x) * psrb_pkg::RECIP3;
		py3 = psrb_pkg::PROD_W'(in_ch.src_y) * psrb_pkg::RECIP3;
		px5 = psrb_pkg::PROD_W'(in_ch.src_x) * psrb_pkg::RECIP5;
		py5 = psrb_pkg::PROD_W'(in_ch.src_y) * psrb_pkg::RECIP5;
		if (src_format_q == psrb_pkg::FMT_ARGB) begin
			argb = in_ch.pixel | psrb_pkg::ALPHA_MASK;
		end else begin
			// fields shifted into place, low bits left at zero
			argb = {8'hff, in_ch.pixel[15:11], 3'b000, in_ch.pixel[10:5], 2'b00,
				in_ch.pixel[4:0], 3'b000};
		end
	end

	logic [psrb_pkg::X_W-1:0]    x_s1, y_s1;
	logic [psrb_pkg::Q_W-1:0]    qx3_s1, qy3_s1, qx5_s1, qy5_s1;
	logic [psrb_pkg::DATA_W-1:0] data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take_in || (v_s1 && !free2);
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			x_s1    <= in_ch.src_x;
			y_s1    <= in_ch.src_y;
			qx3_s1  <= psrb_pkg::Q_W'(px3 >> psrb_pkg::RECIP_SHIFT);
			qy3_s1  <= psrb_pkg::Q_W'(py3 >> psrb_pkg::RECIP_SHIFT);
			qx5_s1  <= psrb_pkg::Q_W'(px5 >> psrb_pkg::RECIP_SHIFT);
			qy5_s1  <= psrb_pkg::Q_W'(py5 >> psrb_pkg::RECIP_SHIFT);
			data_s1 <= argb;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: candidate positions and on-screen mask
	// ---------------------------------------------------------------
	logic            dx, dy;
	psrb_pkg::coord_t xc, yc, ca, cb, c5, r5;
	psrb_pkg::coord_t cand_c [psrb_pkg::NSLOT];
	psrb_pkg::coord_t cand_r [psrb_pkg::NSLOT];
	logic [psrb_pkg::NSLOT-1:0] cand_on, cand_mask;

	always_comb begin
		xc = psrb_pkg::COORD_W'(x_s1);
		yc = psrb_pkg::COORD_W'(y_s1);
		// nonzero multiple of three: the column or row that gets duplicated
		dx = (x_s1 != '0) &&
			(x_s1 == psrb_pkg::X_W'(psrb_pkg::X_W'(qx3_s1) * psrb_pkg::X_W'(3)));
		dy = (y_s1 != '0) &&
			(y_s1 == psrb_pkg::X_W'(psrb_pkg::X_W'(qy3_s1) * psrb_pkg::X_W'(3)));
		// v + (v - 1) / 3, zero for v zero
		ca = xc + psrb_pkg::COORD_W'(qx3_s1) - psrb_pkg::COORD_W'(dx);
		cb = psrb_pkg::COORD_W'(vert_offset_q) + yc + psrb_pkg::COORD_W'(qy3_s1)
			- psrb_pkg::COORD_W'(dy);
		c5 = xc - psrb_pkg::COORD_W'(qx5_s1);
		r5 = yc - psrb_pkg::COORD_W'(qy5_s1);

		for (int i = 0; i < psrb_pkg::NSLOT; i++) begin
			cand_c[i] = '0;
			cand_r[i] = '0;
		end
		cand_mask = '0;
		case (scale_mode_q)
			psrb_pkg::MODE_ONE: begin
				cand_c[0] = xc;
				cand_r[0] = yc;
				cand_mask = 4'b0001;
			end
			psrb_pkg::MODE_DOUBLE: begin
				cand_c[0] = {xc[psrb_pkg::COORD_W-2:0], 1'b0};
				cand_r[0] = {yc[psrb_pkg::COORD_W-2:0], 1'b0};
				cand_c[1] = {xc[psrb_pkg::COORD_W-2:0], 1'b1};
				cand_r[1] = {yc[psrb_pkg::COORD_W-2:0], 1'b0};
				cand_c[2] = {xc[psrb_pkg::COORD_W-2:0], 1'b0};
				cand_r[2] = {yc[psrb_pkg::COORD_W-2:0], 1'b1};
				cand_c[3] = {xc[psrb_pkg::COORD_W-2:0], 1'b1};
				cand_r[3] = {yc[psrb_pkg::COORD_W-2:0], 1'b1};
				cand_mask = 4'b1111;
			end
			psrb_pkg::MODE_UP34: begin
				// order: base, row below, diagonal, column right
				cand_c[0] = ca;
				cand_r[0] = cb;
				cand_c[1] = ca;
				cand_r[1] = cb + psrb_pkg::COORD_W'(1);
				cand_c[2] = ca + psrb_pkg::COORD_W'(1);
				cand_r[2] = cb + psrb_pkg::COORD_W'(1);
				cand_c[3] = ca + psrb_pkg::COORD_W'(1);
				cand_r[3] = cb;
				cand_mask = {dx, dx && dy, dy, 1'b1};
			end
			default: begin
				cand_c[0] = c5;
				cand_r[0] = r5;
				cand_mask = 4'b0001;
			end
		endcase
		for (int i = 0; i < psrb_pkg::NSLOT; i++) begin
			cand_on[i] = cand_mask[i] && (cand_c[i] < WIDTH_C) && (cand_r[i] < HEIGHT_C);
		end
	end

	psrb_pkg::coord_t            c_s2 [psrb_pkg::NSLOT];
	psrb_pkg::coord_t            r_s2 [psrb_pkg::NSLOT];
	logic [psrb_pkg::NSLOT-1:0]  mask_s2;
	logic [psrb_pkg::DATA_W-1:0] data_s2;

	// pick the lowest pending slot, one write per cycle while the rotation stage is ready
	logic [psrb_pkg::NSLOT-1:0]  low_bit, rest;
	logic [psrb_pkg::SLOT_W-1:0] sel;

	always_comb begin
		low_bit = mask_s2 & (~mask_s2 + psrb_pkg::NSLOT'(1));
		rest    = mask_s2 & ~low_bit;
		sel     = '0;
		for (int i = psrb_pkg::NSLOT - 1; i >= 0; i--) begin
			if (mask_s2[i]) begin
				sel = psrb_pkg::SLOT_W'(i);
			end
		end
	end

	assign send  = v_s2 && (mask_s2 != '0) && rdy3;
	// the candidate stage empties when nothing is pending or its last write leaves
	assign free2 = !v_s2 || (mask_s2 == '0) || ((rest == '0) && rdy3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			mask_s2 <= '0;
		end else begin
			v_s2 <= ld2 || (v_s2 && !free2);
			if (ld2) begin
				mask_s2 <= cand_on;
			end else if (send) begin
				mask_s2 <= rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			c_s2    <= cand_c;
			r_s2    <= cand_r;
			data_s2 <= data_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: rotation by 180 degrees
	// ---------------------------------------------------------------
	logic [ROW_W-1:0]            row_s3;
	logic [COL_W-1:0]            col_s3;
	logic [psrb_pkg::DATA_W-1:0] data_s3;
	logic                        last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= send;
		end
	end

	always_ff @(posedge clk) begin
		if (send) begin
			row_s3  <= ROW_MAX - ROW_W'(r_s2[sel]);
			col_s3  <= COL_MAX - COL_W'(c_s2[sel]);
			data_s3 <= data_s2;
			last_s3 <= (rest == '0);
		end
	end

	// ---------------------------------------------------------------
	// stage 4: row times screen width
	// ---------------------------------------------------------------
	logic [psrb_pkg::ADDR_W-1:0] prod_s4;
	logic [COL_W-1:0]            col_s4;
	logic [psrb_pkg::DATA_W-1:0] data_s4;
	logic                        last_s4;
	logic [MUL_W-1:0]            row_prod;

	assign row_prod = MUL_W'(row_s3) * MUL_W'(WIDTH_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && rdy4) begin
			prod_s4 <= psrb_pkg::ADDR_W'(row_prod);
			col_s4  <= col_s3;
			data_s4 <= data_s3;
			last_s4 <= last_s3;
		end
	end

	// ---------------------------------------------------------------
	// stage 5: output register, buffer base added, address wraps at 20 bits
	// ---------------------------------------------------------------
	logic [psrb_pkg::ADDR_W-1:0] addr_s5;
	logic [psrb_pkg::DATA_W-1:0] data_s5;
	logic                        last_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && rdy5) begin
			addr_s5 <= (back_buffer_q ? BUF_BASE : '0) + prod_s4
				+ psrb_pkg::ADDR_W'(col_s4);
			data_s5 <= data_s4;
			last_s5 <= last_s4;
		end
	end

	assign out_ch.valid        = v_s5;
	assign out_ch.word_address = addr_s5;
	assign out_ch.word_data    = data_s5;
	assign out_ch.last_write   = last_s5;

endmodule

// ===== hdl/psrb_checker.sv =====
// psrb_checker: port-level assertions on the blitter's write channel, bound to the top level
// depends on psrb_pkg and pixel_scale_rotate_blitter
module psrb_checker #(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [psrb_pkg::ADDR_W-1:0]   word_address,
	input logic [psrb_pkg::DATA_W-1:0]   word_data,
	input logic                          last_write
);

	localparam longint SPAN = 2 * longint'(SCREEN_WIDTH) * longint'(SCREEN_HEIGHT);
	localparam bit     WRAPS = SPAN > (64'd1 << psrb_pkg::ADDR_W);
	localparam logic [psrb_pkg::ADDR_W:0] SPAN_C = (psrb_pkg::ADDR_W + 1)'(SPAN);

	// a stalled write beat keeps its valid and payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(word_address)
			&& $stable(word_data) && $stable(last_write))
		else $error("write beat changed while stalled");

	// every written word is opaque
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> word_data[31:24] == 8'hff)
		else $error("write without forced alpha");

	// addresses stay inside the two buffers unless the span wraps
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> WRAPS || ({1'b0, word_address} < SPAN_C))
		else $error("write address beyond both buffers");

endmodule

bind pixel_scale_rotate_blitter psrb_checker #(
	.SCREEN_WIDTH  (SCREEN_WIDTH),
	.SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_psrb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.word_address (out_ch.word_address),
	.word_data    (out_ch.word_data),
	.last_write   (out_ch.last_write)
);

// ===== dv/tb.sv =====
// tb: self-checking bench for pixel_scale_rotate_blitter, with directed and random pixel traffic
// depends on psrb_pkg, psrb_in_if, psrb_out_if and the blitter top level
`timescale 1ns / 1ps

module tb;

	localparam int SCREEN_W     = 640;
	localparam int SCREEN_H     = 480;
	localparam int DRAIN_TAIL   = 16;      // pipeline depth plus margin, after the last write
	localparam int LIMIT_CYCLES = 200000;
	localparam int MAX_REPORTS  = 10;

	// one framebuffer word write as the blitter should issue it
	typedef struct packed {
		logic [psrb_pkg::ADDR_W-1:0] addr;
		logic [psrb_pkg::DATA_W-1:0] data;
		logic                        last;
	} fb_write_t;
	typedef fb_write_t fb_write_q_t[$];

	logic clk = 1'b0;
	logic arst_n;
	logic                          cfg_we;
	logic [psrb_pkg::IDX_W-1:0]    cfg_index;
	logic [psrb_pkg::CFG_W-1:0]    cfg_data;

	psrb_in_if  in_ch ();
	psrb_out_if out_ch ();

	pixel_scale_rotate_blitter #(
		.SCREEN_WIDTH  (SCREEN_W),
		.SCREEN_HEIGHT (SCREEN_H)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bench copy of the register file, updated once all four writes are issued
	psrb_pkg::scale_mode_t         cfg_mode;
	psrb_pkg::src_format_t         cfg_fmt;
	logic [psrb_pkg::OFS_W-1:0]    cfg_vofs;
	logic                          cfg_buf;

	// writes still owed by the blitter, oldest first
	fb_write_t pending_writes[$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned cycle_count;
	int unsigned error_count;
	int unsigned pixels_sent;
	int unsigned writes_seen;

	// three-to-four stretch: every third source line gets an extra screen line after it
	function automatic int unsigned stretch_by_third(input logic [psrb_pkg::X_W-1:0] v);
		return (v == 0) ? 0 : v + (v - 1) / 3;
	endfunction

	// expected writes for one source pixel under the current register settings
	function automatic fb_write_q_t predict_writes(input logic [psrb_pkg::X_W-1:0] x,
	                                               input logic [psrb_pkg::X_W-1:0] y,
	                                               input logic [psrb_pkg::DATA_W-1:0] pix);
		int unsigned col[$];
		int unsigned row[$];
		int unsigned a;
		int unsigned b;
		int unsigned addr;
		logic dx;
		logic dy;
		logic [psrb_pkg::DATA_W-1:0] argb;
		fb_write_t w;
		fb_write_q_t res;

		// rgb565 fields are shifted into place, no bit replication; upper half ignored
		if (cfg_fmt == psrb_pkg::FMT_ARGB)
			argb = pix | psrb_pkg::ALPHA_MASK;
		else
			argb = {8'hff, pix[15:11], 3'b000, pix[10:5], 2'b00, pix[4:0], 3'b000};

		case (cfg_mode)
			psrb_pkg::MODE_ONE: begin
				col.push_back(x);
				row.push_back(y);
			end
			psrb_pkg::MODE_DOUBLE: begin
				// row-major order over the 2x2 block
				for (int i = 0; i < 4; i++) begin
					col.push_back(2 * x + i % 2);
					row.push_back(2 * y + i / 2);
				end
			end
			psrb_pkg::MODE_UP34: begin
				a  = stretch_by_third(x);
				b  = cfg_vofs + stretch_by_third(y);
				dx = (x != 0) && (x % 3 == 0);
				dy = (y != 0) && (y % 3 == 0);
				col.push_back(a);
				row.push_back(b);
				if (dy) begin
					col.push_back(a);
					row.push_back(b + 1);
					if (dx) begin
						col.push_back(a + 1);
						row.push_back(b + 1);
					end
				end
				if (dx) begin
					col.push_back(a + 1);
					row.push_back(b);
				end
			end
			default: begin
				col.push_back(x - x / 5);
				row.push_back(y - y / 5);
			end
		endcase

		// off-screen positions vanish; the rest are rotated by 180 degrees
		foreach (col[i]) begin
			if (col[i] < SCREEN_W && row[i] < SCREEN_H) begin
				addr = cfg_buf * SCREEN_W * SCREEN_H + (SCREEN_H - 1 - row[i]) * SCREEN_W +
				       (SCREEN_W - 1 - col[i]);
				w.addr = psrb_pkg::ADDR_W'(addr);
				w.data = argb;
				w.last = 1'b0;
				res.push_back(w);
			end
		end
		if (res.size() > 0)
			res[res.size() - 1].last = 1'b1;
		return res;
	endfunction

	// all four registers in consecutive cycles; only called with nothing in flight
	task automatic set_config(input logic [psrb_pkg::CFG_W-1:0] mode_raw,
	                          input logic [psrb_pkg::CFG_W-1:0] fmt_raw,
	                          input logic [psrb_pkg::CFG_W-1:0] vofs_raw,
	                          input logic [psrb_pkg::CFG_W-1:0] buf_raw);
		cfg_we    <= 1'b1;
		cfg_index <= psrb_pkg::REG_SCALE_MODE;
		cfg_data  <= mode_raw;
		@(posedge clk);
		cfg_index <= psrb_pkg::REG_SRC_FORMAT;
		cfg_data  <= fmt_raw;
		@(posedge clk);
		cfg_index <= psrb_pkg::REG_VERT_OFFSET;
		cfg_data  <= vofs_raw;
		@(posedge clk);
		cfg_index <= psrb_pkg::REG_BACK_BUFFER;
		cfg_data  <= buf_raw;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_mode  = psrb_pkg::scale_mode_t'(mode_raw[psrb_pkg::MODE_W-1:0]);
		cfg_fmt   = psrb_pkg::src_format_t'(fmt_raw[0]);
		cfg_vofs  = vofs_raw[psrb_pkg::OFS_W-1:0];
		cfg_buf   = buf_raw[0];
	endtask

	// one source pixel beat; valid is left high after acceptance so that
	// back-to-back beats need no second assignment in the same step
	task automatic send_pixel(input logic [psrb_pkg::X_W-1:0] x,
	                          input logic [psrb_pkg::X_W-1:0] y,
	                          input logic [psrb_pkg::DATA_W-1:0] pix);
		fb_write_q_t owed;

		owed = predict_writes(x, y, pix);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.src_x <= x;
		in_ch.src_y <= y;
		in_ch.pixel <= pix;
		do
			@(posedge clk);
		while (!in_ch.ready);
		foreach (owed[i])
			pending_writes.push_back(owed[i]);
		pixels_sent++;
	endtask

	// stop sending and wait for every owed write; the tail covers pixels still
	// in the pipe that give no write at all
	task automatic drain(input bit with_tail);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_writes.size() != 0)
			@(posedge clk);
		if (with_tail)
			repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// one-to-one, rgb565: screen corners, upper half of the pixel ignored, both edges off screen
	task automatic test_one_to_one();
		drain(1);
		set_config(psrb_pkg::MODE_ONE, psrb_pkg::FMT_RGB565, 9'd0, 9'd0);
		send_pixel(10'd0, 10'd0, 32'hffff_ffff);
		send_pixel(10'd639, 10'd479, 32'h0000_f800);
		send_pixel(10'd640, 10'd0, 32'h1234_07e0);
		send_pixel(10'd0, 10'd480, 32'h0000_001f);
		send_pixel(10'd1023, 10'd1023, 32'h0000_0000);
		drain(1);
	endtask

	// double, argb, second buffer: full blocks, edge blocks and blocks past the screen
	task automatic test_double();
		set_config(psrb_pkg::MODE_DOUBLE, psrb_pkg::FMT_ARGB, 9'd0, 9'd1);
		send_pixel(10'd0, 10'd0, 32'h0000_0000);
		send_pixel(10'd319, 10'd239, 32'h00ab_cdef);
		send_pixel(10'd320, 10'd5, 32'h7f00_ff00);
		send_pixel(10'd10, 10'd240, 32'hffff_ffff);
		drain(1);
	endtask

	// three-to-four: duplicated rows and columns, partial clip at the corner, large offsets
	task automatic test_three_to_four();
		set_config(psrb_pkg::MODE_UP34, psrb_pkg::FMT_RGB565, 9'd0, 9'd0);
		send_pixel(10'd0, 10'd0, 32'h0000_ffff);
		send_pixel(10'd3, 10'd3, 32'h5555_aaaa);
		send_pixel(10'd3, 10'd1, 32'h0000_1234);
		send_pixel(10'd1, 10'd3, 32'hdead_beef);
		send_pixel(10'd480, 10'd360, 32'h0000_f81f);
		send_pixel(10'd478, 10'd358, 32'h0000_07e0);
		drain(1);
		// offset pushes everything below the screen: no write at all
		set_config(psrb_pkg::MODE_UP34, psrb_pkg::FMT_RGB565, 9'd511, 9'd0);
		send_pixel(10'd0, 10'd0, 32'h0000_8001);
		drain(1);
		// offset lands the duplicated row just past the last line
		set_config(psrb_pkg::MODE_UP34, psrb_pkg::FMT_ARGB, 9'd476, 9'd1);
		send_pixel(10'd3, 10'd3, 32'h0102_0304);
		drain(1);
	endtask

	// five-to-four: dropped columns and rows, last visible position and past it
	task automatic test_five_to_four();
		set_config(psrb_pkg::MODE_DOWN54, psrb_pkg::FMT_ARGB, 9'd0, 9'd1);
		send_pixel(10'd0, 10'd0, 32'h8000_0001);
		send_pixel(10'd4, 10'd4, 32'h0000_0000);
		send_pixel(10'd5, 10'd5, 32'h00ff_ffff);
		send_pixel(10'd798, 10'd598, 32'h1357_9bdf);
		send_pixel(10'd799, 10'd599, 32'h2468_ace0);
		send_pixel(10'd1023, 10'd1023, 32'hffff_ffff);
		drain(1);
	endtask

	// random settings and pixels under each idling pattern
	task automatic test_random_traffic();
		int unsigned idle_of_phase[4]  = '{0, 72, 0, 9};
		int unsigned stall_of_phase[4] = '{0, 0, 72, 9};
		int unsigned max_x;
		int unsigned max_y;
		logic [psrb_pkg::CFG_W-1:0] vofs;

		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = idle_of_phase[p];
			recv_stall_pct = stall_of_phase[p];
			for (int b = 0; b < 4; b++) begin
				drain(1);
				case ($urandom_range(7))
					0:       vofs = 9'd0;
					1:       vofs = 9'd511;
					2:       vofs = 9'd479;
					default: vofs = psrb_pkg::CFG_W'($urandom_range(479));
				endcase
				// unused upper data bits carry junk that the block must mask
				set_config({7'($urandom), 2'($urandom_range(3))},
				           {8'($urandom), 1'($urandom_range(1))}, vofs,
				           {8'($urandom), 1'($urandom_range(1))});
				// keep most pixels on screen for the mode so the writes are exercised
				case (cfg_mode)
					psrb_pkg::MODE_ONE:    begin max_x = 639; max_y = 479; end
					psrb_pkg::MODE_DOUBLE: begin max_x = 319; max_y = 239; end
					psrb_pkg::MODE_UP34:   begin max_x = 479; max_y = 359; end
					default:               begin max_x = 799; max_y = 599; end
				endcase
				for (int i = 0; i < 18; i++) begin
					// mid-batch hold-off until the blitter has caught up
					if (i == 9)
						drain(0);
					if ($urandom_range(99) < 15)
						send_pixel(psrb_pkg::X_W'($urandom), psrb_pkg::X_W'($urandom),
						           $urandom);
					else
						send_pixel(psrb_pkg::X_W'($urandom_range(max_x)),
						           psrb_pkg::X_W'($urandom_range(max_y)), $urandom);
				end
			end
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	// receiver: random stalls, every write beat checked against the oldest owed write
	always @(posedge clk) begin : write_checker
		fb_write_t want;

		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && out_ch.valid && out_ch.ready) begin
			writes_seen++;
			if (pending_writes.size() == 0) begin
				if (error_count < MAX_REPORTS)
					$display("unexpected write beat: addr %0d data %h last %b",
					         out_ch.word_address, out_ch.word_data, out_ch.last_write);
				error_count++;
			end else begin
				want = pending_writes.pop_front();
				if (out_ch.word_address !== want.addr || out_ch.word_data !== want.data ||
				    out_ch.last_write !== want.last) begin
					if (error_count < MAX_REPORTS)
						$display("write %0d mismatch: expected addr %0d data %h last %b,",
						         writes_seen, want.addr, want.data, want.last,
						         " got addr %0d data %h last %b",
						         out_ch.word_address, out_ch.word_data, out_ch.last_write);
					error_count++;
				end
			end
		end
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		// every input known from time zero while reset is held
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = psrb_pkg::REG_SCALE_MODE;
		cfg_data       = '0;
		in_ch.valid    = 1'b0;
		in_ch.src_x    = '0;
		in_ch.src_y    = '0;
		in_ch.pixel    = '0;
		out_ch.ready   = 1'b0;
		cycle_count    = 0;
		error_count    = 0;
		pixels_sent    = 0;
		writes_seen    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		cfg_mode       = psrb_pkg::MODE_ONE;
		cfg_fmt        = psrb_pkg::FMT_RGB565;
		cfg_vofs       = '0;
		cfg_buf        = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_one_to_one();
		test_double();
		test_three_to_four();
		test_five_to_four();
		test_random_traffic();
		drain(1);

		if (pending_writes.size() != 0) begin
			$display("%0d expected writes never arrived", pending_writes.size());
			error_count += pending_writes.size();
		end
		$display("sent %0d pixels, checked %0d framebuffer writes", pixels_sent, writes_seen);
		$display("all four scale modes, both pixel formats and buffers, four idling patterns");
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
